/* src/artnet_dmx_frame_assembler_assert.svh */
// Assertion macros used by the top-level RTL file of the Art-Net frame assembler.
`ifndef ARTNET_DMX_FRAME_ASSEMBLER_ASSERT_SVH
`define ARTNET_DMX_FRAME_ASSEMBLER_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted
`define ADFA_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("adfa assertion failed");

// Next-cycle implication, disabled while reset is asserted
`define ADFA_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("adfa assertion failed");

`endif

/* src/adfa_pkg.sv */
package adfa_pkg;

    // Sizing
    localparam int FRAME_DEPTH         = 256;
    localparam int PIXELS_PER_UNIVERSE = 170;
    localparam int MAX_PACKET          = 600;

    localparam int FRAME_AW = (FRAME_DEPTH > 1) ? $clog2(FRAME_DEPTH) : 1;

    // Port field widths
    localparam int OP_W       = 2;
    localparam int BYTE_W     = 8;
    localparam int IDX_W      = 8;
    localparam int COLOR_W    = 24;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // Register and header word widths
    localparam int TOTAL_W = 9;
    localparam int HOLD_W  = 16;
    localparam int WORD_W  = 16;

    // Derived datapath widths
    localparam int POS_W  = $clog2(MAX_PACKET + 1);
    localparam int PIX_W  = $clog2(MAX_PACKET / 3 + 1);
    localparam int BASE_W = WORD_W + $clog2(PIXELS_PER_UNIVERSE + 1);
    localparam int PT_W   = (FRAME_AW + 1 > TOTAL_W) ? FRAME_AW + 1 : TOTAL_W;

    // Input operation codes
    localparam logic [OP_W-1:0] OP_BYTE = 2'd0;
    localparam logic [OP_W-1:0] OP_TICK = 2'd1;
    localparam logic [OP_W-1:0] OP_READ = 2'd2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_ENABLE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TOTAL  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_HOLD   = 2'd2;

    // Configuration reset values
    localparam logic [TOTAL_W-1:0] TOTAL_RESET = 9'd256;
    localparam logic [HOLD_W-1:0]  HOLD_RESET  = 16'd5000;

    // Art-Net opcodes
    localparam logic [WORD_W-1:0] OPC_DMX  = 16'h5000;
    localparam logic [WORD_W-1:0] OPC_POLL = 16'h2000;

    // Header layout (byte positions)
    localparam int SIG_LEN    = 8;
    localparam int POS_OPC_LO = 8;
    localparam int POS_OPC_HI = 9;
    localparam int MIN_HEADER = 12;
    localparam int POS_UNI_LO = 14;
    localparam int POS_UNI_HI = 15;
    localparam int POS_LEN_HI = 16;
    localparam int POS_LEN_LO = 17;
    localparam int MIN_DMX    = 18;

    // "Art-Net" followed by a zero byte
    localparam logic [BYTE_W-1:0] SIG_BYTES [SIG_LEN] = '{
        8'h41, 8'h72, 8'h74, 8'h2D, 8'h4E, 8'h65, 8'h74, 8'h00
    };

    typedef enum logic {
        ST_IDLE,
        ST_LOOKUP
    } ctrl_state_t;

    // Controller to datapath
    typedef struct packed {
        logic take;   // input transaction: update parser, timer, store
        logic load;   // move staged result into the output register
    } dp_cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;  // output register empty or being taken
    } dp_status_t;

endpackage

/* src/adfa_in_if.sv */
interface adfa_in_if;
    logic                          valid;
    logic                          ready;
    logic [adfa_pkg::OP_W-1:0]     op;
    logic [adfa_pkg::BYTE_W-1:0]   data_byte;
    logic                          last;
    logic [adfa_pkg::IDX_W-1:0]    pixel_index;

    modport source (output valid, output op, output data_byte, output last,
                    output pixel_index, input ready);
    modport sink   (input valid, input op, input data_byte, input last,
                    input pixel_index, output ready);
endinterface

/* src/adfa_out_if.sv */
interface adfa_out_if;
    logic                          valid;
    logic                          ready;
    logic [adfa_pkg::COLOR_W-1:0]  pixel_color;
    logic                          display_owned;
    logic                          poll_reply_due;
    logic                          dmx_accepted;

    modport source (output valid, output pixel_color, output display_owned,
                    output poll_reply_due, output dmx_accepted, input ready);
    modport sink   (input valid, input pixel_color, input display_owned,
                    input poll_reply_due, input dmx_accepted, output ready);
endinterface

/* src/adfa_cfg_if.sv */
interface adfa_cfg_if;
    logic                             valid;
    logic                             ready;
    logic [adfa_pkg::CFG_IDX_W-1:0]   index;
    logic [adfa_pkg::CFG_DATA_W-1:0]  data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* src/artnet_dmx_frame_assembler.sv */
// Flow: an accepted input transaction updates the staged result and the
// registered frame-store read; the controller then moves to ST_LOOKUP, which
// loads the output register, and takes no new item until back in ST_IDLE;
// a result waiting in the output register stalls the next item until it is taken.
// Reset (rst_n, async, active low): control registers to defaults, parser idle, hold
// timer zero, all frame-store valid bits cleared at once; no clearing pass.
`include "artnet_dmx_frame_assembler_assert.svh"

module artnet_dmx_frame_assembler (
    input  logic       clk,
    input  logic       rst_n,
    adfa_in_if.sink    item,
    adfa_out_if.source result,
    adfa_cfg_if.sink   cfg
);

    adfa_pkg::dp_cmd_t    ctl_cmd;
    adfa_pkg::dp_status_t dp_status;

    // Register writes are always taken
    assign cfg.ready = 1'b1;

    // Sequencer
    adfa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (item.valid),
        .in_ready (item.ready),
        .status   (dp_status),
        .cmd      (ctl_cmd)
    );

    // Parser, timer, frame store and result register
    adfa_datapath u_datapath (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (ctl_cmd),
        .status         (dp_status),
        .op             (item.op),
        .data_byte      (item.data_byte),
        .last           (item.last),
        .pixel_index    (item.pixel_index),
        .cfg_valid      (cfg.valid),
        .cfg_index      (cfg.index),
        .cfg_data       (cfg.data),
        .out_valid      (result.valid),
        .out_ready      (result.ready),
        .pixel_color    (result.pixel_color),
        .display_owned  (result.display_owned),
        .poll_reply_due (result.poll_reply_due),
        .dmx_accepted   (result.dmx_accepted)
    );

    // Checks
    `ADFA_ASSERT_NXT(a_accept_starts_lookup, clk, rst_n, item.valid && item.ready, ctl_cmd.load)
    `ADFA_ASSERT_NXT(a_lookup_fills_output, clk, rst_n, ctl_cmd.load, result.valid)
    `ADFA_ASSERT_IMP(a_no_accept_in_lookup, clk, rst_n, ctl_cmd.load, !item.ready)
    `ADFA_ASSERT_IMP(a_color_needs_owner, clk, rst_n,
        result.valid && (result.pixel_color != '0), result.display_owned)

endmodule

/* src/adfa_ctrl.sv */
module adfa_ctrl (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  adfa_pkg::dp_status_t status,
    output adfa_pkg::dp_cmd_t    cmd
);

    adfa_pkg::ctrl_state_t state_reg, state_next;

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= adfa_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            adfa_pkg::ST_IDLE:
            begin
                if (in_valid && in_ready)
                begin
                    state_next = adfa_pkg::ST_LOOKUP;
                end
            end
            adfa_pkg::ST_LOOKUP:
            begin
                state_next = adfa_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = adfa_pkg::ST_IDLE;
            end
        endcase
    end

    // Outputs: take a transaction only when the result slot will be free
    always_comb
    begin
        in_ready = 1'b0;
        cmd.load = 1'b0;
        unique case (state_reg)
            adfa_pkg::ST_IDLE:
            begin
                in_ready = status.out_free;
            end
            adfa_pkg::ST_LOOKUP:
            begin
                cmd.load = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
        cmd.take = in_valid && in_ready;
    end

endmodule

/* src/adfa_datapath.sv */
module adfa_datapath (
    input  logic                               clk,
    input  logic                               rst_n,
    input  adfa_pkg::dp_cmd_t                  cmd,
    output adfa_pkg::dp_status_t               status,
    // input item
    input  logic [adfa_pkg::OP_W-1:0]          op,
    input  logic [adfa_pkg::BYTE_W-1:0]        data_byte,
    input  logic                               last,
    input  logic [adfa_pkg::IDX_W-1:0]         pixel_index,
    // register writes
    input  logic                               cfg_valid,
    input  logic [adfa_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [adfa_pkg::CFG_DATA_W-1:0]    cfg_data,
    // result
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic [adfa_pkg::COLOR_W-1:0]       pixel_color,
    output logic                               display_owned,
    output logic                               poll_reply_due,
    output logic                               dmx_accepted
);

    localparam int AW      = adfa_pkg::FRAME_AW;
    localparam int DEPTH   = adfa_pkg::FRAME_DEPTH;
    localparam int POS_W   = adfa_pkg::POS_W;
    localparam int PIX_W   = adfa_pkg::PIX_W;
    localparam int BASE_W  = adfa_pkg::BASE_W;
    localparam int PT_W    = adfa_pkg::PT_W;
    localparam int WORD_W  = adfa_pkg::WORD_W;
    localparam int HOLD_W  = adfa_pkg::HOLD_W;
    localparam int TOTAL_W = adfa_pkg::TOTAL_W;
    localparam int BYTE_W  = adfa_pkg::BYTE_W;
    localparam int COLOR_W = adfa_pkg::COLOR_W;
    localparam int ADDR_W  = BASE_W + 1;

    localparam logic [POS_W-1:0] P_MAX     = POS_W'(adfa_pkg::MAX_PACKET);
    localparam logic [POS_W-1:0] P_SIG_LEN = POS_W'(adfa_pkg::SIG_LEN);
    localparam logic [POS_W-1:0] P_OPC_LO  = POS_W'(adfa_pkg::POS_OPC_LO);
    localparam logic [POS_W-1:0] P_OPC_HI  = POS_W'(adfa_pkg::POS_OPC_HI);
    localparam logic [POS_W-1:0] P_UNI_LO  = POS_W'(adfa_pkg::POS_UNI_LO);
    localparam logic [POS_W-1:0] P_UNI_HI  = POS_W'(adfa_pkg::POS_UNI_HI);
    localparam logic [POS_W-1:0] P_LEN_HI  = POS_W'(adfa_pkg::POS_LEN_HI);
    localparam logic [POS_W-1:0] P_LEN_LO  = POS_W'(adfa_pkg::POS_LEN_LO);
    localparam logic [POS_W-1:0] P_MIN_HDR = POS_W'(adfa_pkg::MIN_HEADER);
    localparam logic [POS_W-1:0] P_MIN_DMX = POS_W'(adfa_pkg::MIN_DMX);
    localparam logic [PT_W-1:0]  PT_DEPTH  = PT_W'(DEPTH);

    // Configuration registers
    logic                enable_reg, enable_next;
    logic [TOTAL_W-1:0]  total_reg, total_next;
    logic [HOLD_W-1:0]   hold_ticks_reg, hold_ticks_next;

    // Packet parser
    logic [POS_W-1:0]    pos_reg, pos_next;
    logic                header_good_reg, header_good_next;
    logic [WORD_W-1:0]   opcode_reg, opcode_next;
    logic [WORD_W-1:0]   universe_reg, universe_next;
    logic [WORD_W-1:0]   length_reg, length_next;
    logic [WORD_W-1:0]   color_partial_reg, color_partial_next;
    logic [1:0]          phase_reg, phase_next;
    logic [PIX_W-1:0]    pix_reg, pix_next;
    logic [BASE_W-1:0]   base_reg, base_next;
    logic                parser_clr;

    // Session timer and per-entry valid bits
    logic [HOLD_W-1:0]   hold_left_reg, hold_left_next;
    logic [DEPTH-1:0]    valid_reg;
    logic                clear_all;

    // Staged result of the accepted transaction
    logic                poll_s_reg, poll_s_next;
    logic                acc_s_reg, acc_s_next;
    logic                hit_s_reg, hit_s_next;
    logic                owned_s_reg, owned_s_next;

    // Output register
    logic                out_valid_reg, out_valid_next;
    logic [COLOR_W-1:0]  color_out_reg, color_out_next;
    logic                owned_out_reg, owned_out_next;
    logic                poll_out_reg, poll_out_next;
    logic                acc_out_reg, acc_out_next;

    // Frame store
    logic [COLOR_W-1:0]  mem [DEPTH];
    logic [COLOR_W-1:0]  rd_data_reg;
    logic                rd_en;
    logic                wr_en;
    logic [AW-1:0]       wr_addr;
    logic [COLOR_W-1:0]  wr_data;
    logic [AW-1:0]       rd_addr;

    logic [PT_W-1:0]     pixel_total;
    logic [POS_W-1:0]    dmx_offset;
    logic [ADDR_W-1:0]   pixel_addr;

    // Effective pixel total and write address
    assign pixel_total = (PT_W'(total_reg) < PT_DEPTH) ? PT_W'(total_reg) : PT_DEPTH;
    assign dmx_offset  = pos_reg - P_MIN_DMX;
    assign pixel_addr  = ADDR_W'(base_reg) + ADDR_W'(pix_reg);
    assign rd_addr     = AW'(pixel_index);
    assign wr_addr     = AW'(pixel_addr);
    assign wr_data     = {color_partial_reg, data_byte};
    assign rd_en       = cmd.take && (op == adfa_pkg::OP_READ);

    // Parser, timer, register writes and result staging
    always_comb
    begin
        enable_next        = enable_reg;
        total_next         = total_reg;
        hold_ticks_next    = hold_ticks_reg;
        pos_next           = pos_reg;
        header_good_next   = header_good_reg;
        opcode_next        = opcode_reg;
        universe_next      = universe_reg;
        length_next        = length_reg;
        color_partial_next = color_partial_reg;
        phase_next         = phase_reg;
        pix_next           = pix_reg;
        base_next          = base_reg;
        hold_left_next     = hold_left_reg;
        poll_s_next        = poll_s_reg;
        acc_s_next         = acc_s_reg;
        hit_s_next         = hit_s_reg;
        owned_s_next       = owned_s_reg;
        parser_clr         = 1'b0;
        clear_all          = 1'b0;
        wr_en              = 1'b0;

        if (cmd.take)
        begin
            poll_s_next = 1'b0;
            acc_s_next  = 1'b0;
            hit_s_next  = 1'b0;
            case (op)
                adfa_pkg::OP_BYTE:
                begin
                    if (enable_reg)
                    begin
                        // bytes past the packet limit are dropped
                        if (pos_reg < P_MAX)
                        begin
                            if (pos_reg < P_SIG_LEN)
                            begin
                                if (data_byte != adfa_pkg::SIG_BYTES[pos_reg[2:0]])
                                begin
                                    header_good_next = 1'b0;
                                end
                            end
                            else if (pos_reg == P_OPC_LO)
                            begin
                                opcode_next = {opcode_reg[WORD_W-1:BYTE_W], data_byte};
                            end
                            else if (pos_reg == P_OPC_HI)
                            begin
                                opcode_next = {data_byte, opcode_reg[BYTE_W-1:0]};
                            end
                            else if (pos_reg == P_UNI_LO)
                            begin
                                universe_next = {universe_reg[WORD_W-1:BYTE_W], data_byte};
                            end
                            else if (pos_reg == P_UNI_HI)
                            begin
                                universe_next = {data_byte, universe_reg[BYTE_W-1:0]};
                            end
                            else if (pos_reg == P_LEN_HI)
                            begin
                                length_next = {data_byte, length_reg[BYTE_W-1:0]};
                                // universe is complete: precompute first pixel index
                                base_next = BASE_W'(universe_reg * adfa_pkg::PIXELS_PER_UNIVERSE);
                            end
                            else if (pos_reg == P_LEN_LO)
                            begin
                                length_next = {length_reg[WORD_W-1:BYTE_W], data_byte};
                                // session start wipes the frame
                                if (header_good_reg && (opcode_reg == adfa_pkg::OPC_DMX)
                                    && (hold_left_reg == '0))
                                begin
                                    clear_all = 1'b1;
                                end
                            end
                            else if (pos_reg >= P_MIN_DMX)
                            begin
                                if (header_good_reg && (opcode_reg == adfa_pkg::OPC_DMX))
                                begin
                                    case (phase_reg)
                                        2'd0:
                                        begin
                                            color_partial_next = {data_byte, 8'h00};
                                        end
                                        2'd1:
                                        begin
                                            color_partial_next =
                                                {color_partial_reg[WORD_W-1:BYTE_W], data_byte};
                                        end
                                        default:
                                        begin
                                            if ((WORD_W'(dmx_offset) < length_reg)
                                                && (pixel_addr < ADDR_W'(pixel_total)))
                                            begin
                                                wr_en = 1'b1;
                                            end
                                        end
                                    endcase
                                end
                                // RGB triple counter
                                if (phase_reg == 2'd2)
                                begin
                                    phase_next = 2'd0;
                                    pix_next   = pix_reg + 1'b1;
                                end
                                else
                                begin
                                    phase_next = phase_reg + 1'b1;
                                end
                            end
                            pos_next = pos_reg + 1'b1;
                        end

                        // end of packet: classify and restart the parser
                        if (last)
                        begin
                            if ((pos_next >= P_MIN_HDR) && header_good_next)
                            begin
                                if (opcode_next == adfa_pkg::OPC_POLL)
                                begin
                                    poll_s_next = 1'b1;
                                end
                                else if ((opcode_next == adfa_pkg::OPC_DMX)
                                         && (pos_next >= P_MIN_DMX))
                                begin
                                    acc_s_next     = 1'b1;
                                    hold_left_next = hold_ticks_reg;
                                end
                            end
                            parser_clr = 1'b1;
                        end
                    end
                end
                adfa_pkg::OP_TICK:
                begin
                    if (hold_left_reg != '0)
                    begin
                        hold_left_next = hold_left_reg - 1'b1;
                        if (hold_left_reg == HOLD_W'(1))
                        begin
                            clear_all = 1'b1;
                        end
                    end
                end
                adfa_pkg::OP_READ:
                begin
                    hit_s_next = (hold_left_reg != '0)
                                 && (PT_W'(pixel_index) < pixel_total)
                                 && valid_reg[rd_addr];
                end
                default:
                begin
                end
            endcase
            owned_s_next = (hold_left_next != '0);
        end

        // register writes
        if (cfg_valid)
        begin
            unique case (cfg_index)
                adfa_pkg::REG_ENABLE:
                begin
                    enable_next = cfg_data[0];
                    if (!cfg_data[0])
                    begin
                        parser_clr     = 1'b1;
                        hold_left_next = '0;
                        clear_all      = 1'b1;
                    end
                end
                adfa_pkg::REG_TOTAL:
                begin
                    total_next = cfg_data[TOTAL_W-1:0];
                end
                adfa_pkg::REG_HOLD:
                begin
                    hold_ticks_next = cfg_data[HOLD_W-1:0];
                end
                default:
                begin
                end
            endcase
        end

        if (parser_clr)
        begin
            pos_next           = '0;
            header_good_next   = 1'b1;
            opcode_next        = '0;
            universe_next      = '0;
            length_next        = '0;
            color_partial_next = '0;
            phase_next         = '0;
            pix_next           = '0;
        end
    end

    // Output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        color_out_next = color_out_reg;
        owned_out_next = owned_out_reg;
        poll_out_next  = poll_out_reg;
        acc_out_next   = acc_out_reg;
        if (cmd.load)
        begin
            out_valid_next = 1'b1;
            color_out_next = hit_s_reg ? rd_data_reg : '0;
            owned_out_next = owned_s_reg;
            poll_out_next  = poll_s_reg;
            acc_out_next   = acc_s_reg;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign pixel_color     = color_out_reg;
    assign display_owned   = owned_out_reg;
    assign poll_reply_due  = poll_out_reg;
    assign dmx_accepted    = acc_out_reg;

    // Control and parser state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg        <= 1'b0;
            total_reg         <= adfa_pkg::TOTAL_RESET;
            hold_ticks_reg    <= adfa_pkg::HOLD_RESET;
            pos_reg           <= '0;
            header_good_reg   <= 1'b1;
            opcode_reg        <= '0;
            universe_reg      <= '0;
            length_reg        <= '0;
            color_partial_reg <= '0;
            phase_reg         <= '0;
            pix_reg           <= '0;
            base_reg          <= '0;
            hold_left_reg     <= '0;
            poll_s_reg        <= 1'b0;
            acc_s_reg         <= 1'b0;
            hit_s_reg         <= 1'b0;
            owned_s_reg       <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            enable_reg        <= enable_next;
            total_reg         <= total_next;
            hold_ticks_reg    <= hold_ticks_next;
            pos_reg           <= pos_next;
            header_good_reg   <= header_good_next;
            opcode_reg        <= opcode_next;
            universe_reg      <= universe_next;
            length_reg        <= length_next;
            color_partial_reg <= color_partial_next;
            phase_reg         <= phase_next;
            pix_reg           <= pix_next;
            base_reg          <= base_next;
            hold_left_reg     <= hold_left_next;
            poll_s_reg        <= poll_s_next;
            acc_s_reg         <= acc_s_next;
            hit_s_reg         <= hit_s_next;
            owned_s_reg       <= owned_s_next;
            out_valid_reg     <= out_valid_next;
        end
    end

    // Result payload
    always_ff @(posedge clk)
    begin
        color_out_reg <= color_out_next;
        owned_out_reg <= owned_out_next;
        poll_out_reg  <= poll_out_next;
        acc_out_reg   <= acc_out_next;
    end

    // Valid bits: an entry not written since the last clear reads as zero
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (clear_all)
        begin
            valid_reg <= '0;
        end
        else if (wr_en)
        begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule
